// ----- design/dssvm_pkg.sv -----
// package for the drum step sequencer voice mixer: mode codes, orientation codes, shared types
`default_nettype none
package dssvm_pkg;
    localparam logic [2:0] MODE_FRAME   = 3'd0;
    localparam logic [2:0] MODE_SAMPLE  = 3'd1;
    localparam logic [2:0] MODE_DRUMLEN = 3'd2;
    localparam logic [2:0] MODE_PATWORD = 3'd3;
    localparam logic [2:0] MODE_PATLEN  = 3'd4;
    localparam logic [2:0] ORIENT_BACK  = 3'd4;
    localparam logic [2:0] ORIENT_OVER  = 3'd5;
    localparam int MIX_W = 19;
    localparam int SUM_W = 24;

    typedef struct packed {
        logic [2:0]  mode;
        logic        play_toggle;
        logic        fill_tap;
        logic        orient_new;
        logic [2:0]  orient;
        logic [15:0] interval_samples;
        logic [16:0] load_addr;
        logic [15:0] load_value;
    } t_item;
endpackage
`default_nettype wire

// ----- design/dssvm_core.sv -----
// sequencer core: tables, step logic, voice pool walked one entry at a time (S_VOICE, S_ACC) with one adder
`default_nettype none
module dssvm_core #(
    parameter int VOICES        = 16,
    parameter int DRUMS         = 8,
    parameter int PATTERNS      = 8,
    parameter int FILL_INDEX    = 5,
    parameter int SAMPLE_DEPTH  = 16384,
    parameter int PATTERN_DEPTH = 32
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_start,
    input  dssvm_pkg::t_item     i_item,
    output logic                 o_busy,
    output logic                 o_done,
    output logic signed [dssvm_pkg::MIX_W-1:0] o_mix,
    output logic                 o_beat
);
    localparam int DW   = (DRUMS > 1) ? $clog2(DRUMS) : 1;
    localparam int PW   = $clog2(PATTERNS);
    localparam int SW   = $clog2(SAMPLE_DEPTH);
    localparam int SPW  = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
    localparam int VW   = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int DCW  = $clog2(DRUMS + 1);
    localparam int VCW  = $clog2(VOICES + 1);
    localparam int SMEM = DRUMS * SAMPLE_DEPTH;
    localparam int PMEM = PATTERNS * PATTERN_DEPTH;
    localparam int SMW  = $clog2(SMEM);
    localparam int PMW  = $clog2(PMEM);
    localparam int LW   = SW + 1;
    localparam int PTW  = SW + 2;
    localparam int IW   = $clog2(PATTERN_DEPTH + 1);
    localparam int KW   = (IW > 1) ? $clog2(IW) : 1;
    localparam int FILL = FILL_INDEX % PATTERNS;
    localparam logic signed [dssvm_pkg::SUM_W-1:0] MIX_HI =
        dssvm_pkg::SUM_W'((1 << (dssvm_pkg::MIX_W - 1)) - 1);
    localparam logic signed [dssvm_pkg::SUM_W-1:0] MIX_LO = ~MIX_HI;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EVENT = 3'd1;
    localparam logic [2:0] S_START = 3'd2;
    localparam logic [2:0] S_VOICE = 3'd3;
    localparam logic [2:0] S_ACC   = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;
    localparam logic [2:0] S_MOD   = 3'd6;

    logic [2:0] r_state, n_state;

    logic signed [15:0] r_smem [SMEM];
    logic [14:0]        r_dlen [DRUMS];
    logic [DRUMS-1:0]   r_pmem [PMEM];
    logic [5:0]         r_plen [PATTERNS];

    logic           r_playing;
    logic [15:0]    r_icount;
    logic [PW-1:0]  r_cur, r_prev;
    logic [IW-1:0]  r_step;
    logic           r_fill, r_rev;
    logic [VOICES-1:0] r_vact;
    logic [DW-1:0]  r_vdrum [VOICES];
    logic signed [PTW-1:0] r_vptr [VOICES];

    logic [DRUMS-1:0]     r_ev;
    logic [DCW-1:0]       r_dcnt;
    logic [VCW-1:0]       r_vcnt;
    logic [15:0]          r_iv;
    logic                 r_beat;
    logic signed [15:0]   r_sdata;
    logic                 r_sval;
    logic signed [dssvm_pkg::SUM_W-1:0] r_sum;
    logic [IW-1:0]        r_mlen;
    logic [KW-1:0]        r_mk;
    logic                 r_goev;

    function automatic logic [IW-1:0] pat_len(input logic [5:0] n);
        if (32'(n) > PATTERN_DEPTH) return IW'(PATTERN_DEPTH);
        return IW'(n);
    endfunction

    function automatic logic [LW-1:0] drum_len(input logic [14:0] n);
        if (32'(n) > SAMPLE_DEPTH) return LW'(SAMPLE_DEPTH);
        return LW'(n);
    endfunction

    // frame front end, all done on accept
    logic [PW-1:0] f_cur, f_prev;
    logic [IW-1:0] f_step, f_len;
    logic          f_fill, f_rev, f_play;
    logic [15:0]   f_icnt;
    logic          f_go;
    always_comb begin
        f_play = r_playing;
        f_icnt = r_icount;
        f_fill = r_fill;
        f_cur  = r_cur;
        f_prev = r_prev;
        f_step = r_step;
        f_rev  = r_rev;
        if (i_item.play_toggle) begin
            f_play = !r_playing;
            if (!r_playing) f_icnt = '0;
        end
        if (i_item.fill_tap && !r_fill) begin
            f_fill = 1'b1;
            f_prev = r_cur;
            f_cur  = PW'(FILL);
            f_step = '0;
        end
        f_len = pat_len(r_plen[f_cur]);
        if (i_item.orient_new) begin
            f_rev = (i_item.orient == dssvm_pkg::ORIENT_OVER);
            if (i_item.orient <= dssvm_pkg::ORIENT_BACK && 32'(i_item.orient) < PATTERNS)
                f_cur = PW'(i_item.orient);
            f_len = pat_len(r_plen[f_cur]);
            // nonzero length: remainder is taken in S_MOD
            if (f_len == '0) f_step = '0;
        end
        f_go = f_play && (f_icnt == '0);
    end

    // remainder of step by length, one shifted compare and subtract per cycle
    logic [2*IW-1:0] mod_sub;
    assign mod_sub = {{IW{1'b0}}, r_mlen} << r_mk;

    logic [VW-1:0] vi;
    assign vi = r_vcnt[VW-1:0];
    logic [DW-1:0] cur_d;
    assign cur_d = r_vdrum[vi];
    logic signed [PTW-1:0] cur_p;
    assign cur_p = r_vptr[vi];
    logic [LW-1:0] cur_len;
    assign cur_len = drum_len(r_dlen[cur_d]);
    logic cur_ok;
    assign cur_ok = (cur_p >= 0) && (cur_p < $signed({1'b0, cur_len}));

    // first free voice
    logic [VCW-1:0] free_idx;
    logic           free_ok;
    always_comb begin
        free_idx = '0;
        free_ok  = 1'b0;
        for (int v = VOICES - 1; v >= 0; v--) begin
            if (!r_vact[v]) begin
                free_idx = VCW'(v);
                free_ok  = 1'b1;
            end
        end
    end

    logic [DW-1:0] sd;
    assign sd = r_dcnt[DW-1:0];
    logic [IW-1:0] ev_len;
    assign ev_len = pat_len(r_plen[r_cur]);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_start && i_item.mode == dssvm_pkg::MODE_FRAME) begin
                if (i_item.orient_new && f_len != '0) n_state = S_MOD;
                else n_state = f_go ? S_EVENT : S_VOICE;
            end
            S_MOD:   if (r_mk == '0) n_state = r_goev ? S_EVENT : S_VOICE;
            S_EVENT: n_state = S_START;
            S_START: if (r_dcnt == DCW'(DRUMS - 1)) n_state = S_VOICE;
            S_VOICE: n_state = S_ACC;
            S_ACC:   n_state = (r_vcnt == VCW'(VOICES - 1)) ? S_OUT : S_VOICE;
            S_OUT:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_playing <= 1'b0;
            r_icount  <= '0;
            r_cur     <= '0;
            r_prev    <= '0;
            r_step    <= '0;
            r_fill    <= 1'b0;
            r_rev     <= 1'b0;
            r_vact    <= '0;
            r_beat    <= 1'b0;
            for (int v = 0; v < VOICES; v++) begin
                r_vdrum[v] <= '0;
                r_vptr[v]  <= '0;
            end
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_IDLE: if (i_start && i_item.mode == dssvm_pkg::MODE_FRAME) begin
                    r_playing <= f_play;
                    r_fill    <= f_fill;
                    r_cur     <= f_cur;
                    r_prev    <= f_prev;
                    r_step    <= f_step;
                    r_rev     <= f_rev;
                    r_iv      <= (i_item.interval_samples == '0) ? 16'd1
                                 : i_item.interval_samples;
                    r_icount  <= (f_play && f_icnt != '0) ? f_icnt - 16'd1 : f_icnt;
                    r_beat    <= 1'b0;
                    r_vcnt    <= '0;
                    r_dcnt    <= '0;
                    r_sum     <= '0;
                    r_mlen    <= f_len;
                    r_mk      <= KW'(IW - 1);
                    r_goev    <= f_go;
                end
                S_MOD: begin
                    if ({{IW{1'b0}}, r_step} >= mod_sub) r_step <= r_step - mod_sub[IW-1:0];
                    r_mk <= r_mk - KW'(1);
                end
                S_EVENT: begin
                    r_beat   <= 1'b1;
                    r_icount <= r_iv - 16'd1;
                    r_ev     <= (r_step < ev_len) ? r_pmem[PMW'(32'(r_cur) * PATTERN_DEPTH
                                + 32'(r_step[SPW-1:0]))] : '0;
                    if (r_cur != PW'(FILL)) r_fill <= 1'b0;
                    if (32'(r_step) + 1 >= 32'(ev_len)) begin
                        r_step <= '0;
                        if (r_cur == PW'(FILL)) begin
                            r_cur  <= r_prev;
                            r_fill <= 1'b0;
                        end
                    end else begin
                        r_step <= r_step + IW'(1);
                    end
                end
                S_START: begin
                    r_dcnt <= r_dcnt + DCW'(1);
                    if (r_ev[sd] && free_ok) begin
                        r_vact[free_idx[VW-1:0]]  <= 1'b1;
                        r_vdrum[free_idx[VW-1:0]] <= sd;
                        r_vptr[free_idx[VW-1:0]]  <= r_rev
                            ? $signed({1'b0, drum_len(r_dlen[sd])}) - PTW'(1) : '0;
                    end
                end
                S_VOICE: begin
                    r_sval <= r_vact[vi] && cur_ok;
                    if (r_vact[vi]) begin
                        if (!cur_ok) r_vact[vi] <= 1'b0;
                        else r_vptr[vi] <= r_rev ? cur_p - PTW'(1) : cur_p + PTW'(1);
                    end
                end
                S_ACC: begin
                    if (r_sval) r_sum <= r_sum + dssvm_pkg::SUM_W'(r_sdata);
                    r_vcnt <= r_vcnt + VCW'(1);
                end
                S_OUT: ;
                default: ;
            endcase
        end
    end

    // sample memory read port, read data registered; table writes for load items
    always_ff @(posedge i_clk) begin
        if (r_state == S_VOICE)
            r_sdata <= r_smem[SMW'(32'(cur_d) * SAMPLE_DEPTH + 32'(cur_p[SW-1:0]))];
        if (r_state == S_IDLE && i_start) begin
            if (i_item.mode == dssvm_pkg::MODE_SAMPLE && 32'(i_item.load_addr) < SMEM)
                r_smem[i_item.load_addr[SMW-1:0]] <= i_item.load_value;
            if (i_item.mode == dssvm_pkg::MODE_PATWORD && 32'(i_item.load_addr) < PMEM)
                r_pmem[i_item.load_addr[PMW-1:0]] <= i_item.load_value[DRUMS-1:0];
            if (i_item.mode == dssvm_pkg::MODE_DRUMLEN && 32'(i_item.load_addr) < DRUMS)
                r_dlen[i_item.load_addr[DW-1:0]] <= i_item.load_value[15] ? '0
                                                 : i_item.load_value[14:0];
            if (i_item.mode == dssvm_pkg::MODE_PATLEN && 32'(i_item.load_addr) < PATTERNS)
                r_plen[i_item.load_addr[PW-1:0]] <= i_item.load_value[15] ? 6'd0
                    : (i_item.load_value > 16'sd63 ? 6'd63 : i_item.load_value[5:0]);
        end
    end

    logic signed [dssvm_pkg::SUM_W-1:0] half_sum;
    assign half_sum = r_sum >>> 1;

    assign o_busy = (r_state != S_IDLE);
    assign o_done = (r_state == S_OUT);
    assign o_mix  = (half_sum > MIX_HI) ? dssvm_pkg::MIX_W'(MIX_HI)
                  : ((half_sum < MIX_LO) ? dssvm_pkg::MIX_W'(MIX_LO)
                  : dssvm_pkg::MIX_W'(half_sum));
    assign o_beat = r_beat;
endmodule
`default_nettype wire

// ----- design/drum_step_sequencer_voice_mixer.sv -----
// top level: stream ports around the sequencer core with an output register
// a frame item walks each voice in turn (S_VOICE then S_ACC) through the shared
// sample port and adder, after S_EVENT and one S_START per drum on a beat, and after
// the S_MOD remainder steps when a new orientation comes with a nonzero pattern length
// load items are written on accept and give no result; ready is low while a frame runs
// or while a result waits; synchronous active-low reset clears voices and sequencer
`default_nettype none
module drum_step_sequencer_voice_mixer #(
    parameter int VOICES        = 16,
    parameter int DRUMS         = 8,
    parameter int PATTERNS      = 8,
    parameter int FILL_INDEX    = 5,
    parameter int SAMPLE_DEPTH  = 16384,
    parameter int PATTERN_DEPTH = 32
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // mode[2:0], play_toggle[3], fill_tap[4], orient_new[5], orient[8:6],
    // interval_samples[24:9], load_addr[41:25], load_value[57:42], zero fill
    input  wire  [63:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // mix_out[18:0], zero fill
    output logic [23:0] m_axis_tdata,
    // beat_pulse
    output logic        m_axis_tuser
);
    dssvm_pkg::t_item item;
    logic busy, done, beat, r_ovalid, r_obeat;
    logic signed [dssvm_pkg::MIX_W-1:0] mix, r_omix;

    assign item.mode             = s_axis_tdata[2:0];
    assign item.play_toggle      = s_axis_tdata[3];
    assign item.fill_tap         = s_axis_tdata[4];
    assign item.orient_new       = s_axis_tdata[5];
    assign item.orient           = s_axis_tdata[8:6];
    assign item.interval_samples = s_axis_tdata[24:9];
    assign item.load_addr        = s_axis_tdata[41:25];
    assign item.load_value       = s_axis_tdata[57:42];

    assign s_axis_tready = !busy && !r_ovalid && i_rst_n;

    dssvm_core #(
        .VOICES(VOICES), .DRUMS(DRUMS), .PATTERNS(PATTERNS), .FILL_INDEX(FILL_INDEX),
        .SAMPLE_DEPTH(SAMPLE_DEPTH), .PATTERN_DEPTH(PATTERN_DEPTH)
    ) u_core (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_start(s_axis_tvalid && s_axis_tready), .i_item(item),
        .o_busy(busy), .o_done(done), .o_mix(mix), .o_beat(beat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else begin
            if (done) begin
                r_ovalid <= 1'b1;
                r_omix   <= mix;
                r_obeat  <= beat;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {5'd0, r_omix};
    assign m_axis_tuser  = r_obeat;
endmodule
`default_nettype wire
